>>> rtl/mlr_pkg.sv
package mlr_pkg;

    // Longest run that is stepped; longer runs saturate to it.
    localparam int MAX_RUN = 63;
    // Start coordinates keep only this many low bits.
    localparam int COORD_BITS = 10;

    localparam int START_W = 10;
    localparam int RUN_W   = 6;
    localparam int OCT_W   = 3;
    localparam int PIX_W   = 12;
    localparam int DEC_W   = RUN_W + 3;

    localparam logic [RUN_W-1:0]   RUN_CAP    = RUN_W'(MAX_RUN);
    localparam logic [START_W-1:0] START_MASK = START_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [OCT_W-1:0] {
        OCT_SWAP      = 3'd0,
        OCT_IDENT     = 3'd1,
        OCT_NEG_Y     = 3'd2,
        OCT_SWAP_NX   = 3'd3,
        OCT_SWAP_NEG  = 3'd4,
        OCT_NEG_XY    = 3'd5,
        OCT_NEG_X     = 3'd6,
        OCT_SWAP_NY   = 3'd7
    } octant_t;

    typedef struct packed {
        logic [START_W-1:0] start_x;
        logic [START_W-1:0] start_y;
        logic [RUN_W-1:0]   run_x;
        logic [RUN_W-1:0]   rise_y;
        logic [OCT_W-1:0]   octant;
    } seg_in_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    last_pixel;
    } pix_out_t;

    // Segment command handed from the front end to the stepper.
    typedef struct packed {
        logic [PIX_W-1:0]        x0;
        logic [PIX_W-1:0]        y0;
        logic [RUN_W-1:0]        steps;
        logic signed [DEC_W-1:0] d0;
        logic signed [DEC_W-1:0] inc_e;
        logic signed [DEC_W-1:0] inc_ne;
        octant_t                 oct;
    } seg_cmd_t;

    function automatic pix_out_t reflect_pix(input logic [PIX_W-1:0] x,
                                             input logic [PIX_W-1:0] y,
                                             input octant_t oct,
                                             input logic last);
        pix_out_t         p;
        logic [PIX_W-1:0] nx;
        logic [PIX_W-1:0] ny;
        nx = ~x + PIX_W'(1);
        ny = ~y + PIX_W'(1);
        p.last_pixel = last;
        unique case (oct)
            OCT_SWAP: begin
                p.pixel_x = y;  p.pixel_y = x;
            end
            OCT_IDENT: begin
                p.pixel_x = x;  p.pixel_y = y;
            end
            OCT_NEG_Y: begin
                p.pixel_x = x;  p.pixel_y = ny;
            end
            OCT_SWAP_NX: begin
                p.pixel_x = y;  p.pixel_y = nx;
            end
            OCT_SWAP_NEG: begin
                p.pixel_x = ny; p.pixel_y = nx;
            end
            OCT_NEG_XY: begin
                p.pixel_x = nx; p.pixel_y = ny;
            end
            OCT_NEG_X: begin
                p.pixel_x = nx; p.pixel_y = y;
            end
            OCT_SWAP_NY: begin
                p.pixel_x = ny; p.pixel_y = x;
            end
            default: begin
                p.pixel_x = x;  p.pixel_y = y;
            end
        endcase
        return p;
    endfunction

endpackage

>>> rtl/mlr_front.sv
module mlr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mlr_pkg::seg_in_t  s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output mlr_pkg::seg_cmd_t cmd_data
);
    import mlr_pkg::*;

    logic                    valid_reg, valid_next;
    seg_cmd_t                cmd_reg, cmd_next;
    logic [RUN_W-1:0]        run_c;
    logic [RUN_W-1:0]        rise_c;
    logic signed [DEC_W-1:0] two_rise;
    logic signed [DEC_W-1:0] two_run;

    assign s_ready = !valid_reg || cmd_ready;

    always_comb begin
        run_c    = (s_data.run_x > RUN_CAP) ? RUN_CAP : s_data.run_x;
        rise_c   = (s_data.rise_y > run_c) ? run_c : s_data.rise_y;
        two_rise = $signed({2'b00, rise_c, 1'b0});
        two_run  = $signed({2'b00, run_c, 1'b0});

        cmd_next.x0     = {2'b00, s_data.start_x & START_MASK};
        cmd_next.y0     = {2'b00, s_data.start_y & START_MASK};
        cmd_next.steps  = run_c;
        cmd_next.d0     = two_rise - $signed({3'b000, run_c});
        cmd_next.inc_e  = two_rise;
        cmd_next.inc_ne = two_rise - two_run;
        cmd_next.oct    = octant_t'(s_data.octant);
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

>>> rtl/mlr_queue.sv
module mlr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  mlr_pkg::seg_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mlr_pkg::seg_cmd_t rd_data
);
    import mlr_pkg::*;

    seg_cmd_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign wr_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/mlr_stepper.sv
module mlr_stepper (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  mlr_pkg::seg_cmd_t cmd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mlr_pkg::pix_out_t m_data
);
    import mlr_pkg::*;

    logic                    busy_reg, busy_next;
    logic [PIX_W-1:0]        x_reg, x_next;
    logic [PIX_W-1:0]        y_reg, y_next;
    logic [RUN_W-1:0]        left_reg, left_next;
    logic signed [DEC_W-1:0] d_reg, d_next;
    logic signed [DEC_W-1:0] inc_e_reg, inc_e_next;
    logic signed [DEC_W-1:0] inc_ne_reg, inc_ne_next;
    octant_t                 oct_reg, oct_next;
    logic                    out_valid_reg, out_valid_next;
    pix_out_t                out_reg, out_next;
    logic                    out_free;
    logic                    emit;

    assign cmd_ready = !busy_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;

    always_comb begin
        busy_next      = busy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        left_next      = left_reg;
        d_next         = d_reg;
        inc_e_next     = inc_e_reg;
        inc_ne_next    = inc_ne_reg;
        oct_next       = oct_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (!busy_reg && cmd_valid) begin
            busy_next   = 1'b1;
            x_next      = cmd_data.x0;
            y_next      = cmd_data.y0;
            left_next   = cmd_data.steps;
            d_next      = cmd_data.d0;
            inc_e_next  = cmd_data.inc_e;
            inc_ne_next = cmd_data.inc_ne;
            oct_next    = cmd_data.oct;
        end

        if (emit) begin
            out_next       = reflect_pix(x_reg, y_reg, oct_reg, left_reg == '0);
            out_valid_next = 1'b1;
            x_next         = x_reg + 1'b1;
            left_next      = left_reg - 1'b1;
            // A decision of zero or less keeps the row; otherwise step up.
            if (d_reg <= 0) begin
                d_next = d_reg + inc_e_reg;
            end else begin
                d_next = d_reg + inc_ne_reg;
                y_next = y_reg + 1'b1;
            end
            if (left_reg == '0) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg      <= x_next;
        y_reg      <= y_next;
        left_reg   <= left_next;
        d_reg      <= d_next;
        inc_e_reg  <= inc_e_next;
        inc_ne_reg <= inc_ne_next;
        oct_reg    <= oct_next;
        out_reg    <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/midpoint_line_rasterizer_top.sv
// Midpoint line rasterizer.
// The s_ channel takes one segment per transfer: a start point, a run along x,
// a rise along y (clamped to the run) and an octant code that reflects every pixel.
// The m_ channel returns run_x + 1 pixel transfers per segment, in order from the
// start point, with last_pixel set on the final one.
// A front end registers each segment and works out the decision variable and its
// two increments; a two-entry command queue sits between it and the stepper.
// The stepper makes one pixel per cycle while the receiver keeps up, with a single
// add on the decision value. A segment passes the front register, the command
// queue and the stepper's state registers before its first pixel is offered.
// The stepper loads each segment and then steps its pixels, taking no new segment
// until the last pixel is out; up to three further segments can be accepted
// meanwhile, in the front register and the queue.
// When the receiver stalls, the pixel register holds and the stepper waits;
// the queue then fills and s_ready drops.
// Reset clears all valid flags and empties the queue; no transfer is pending after it.
module midpoint_line_rasterizer_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mlr_pkg::seg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mlr_pkg::pix_out_t m_data
);
    import mlr_pkg::*;

    logic     f_valid, f_ready;
    seg_cmd_t f_data;
    logic     q_valid, q_ready;
    seg_cmd_t q_data;

    mlr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    mlr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    mlr_stepper u_stepper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
